@@ design/ccp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared tag codes, result codes, the result record and the field-length
// lookup for the constant pool parser.
// ----------------------------------------------------------------------------
package ccp_pkg;

    // Constant pool tag codes
    localparam logic [7:0] TAG_UTF8          = 8'd1;
    localparam logic [7:0] TAG_INTEGER       = 8'd3;
    localparam logic [7:0] TAG_FLOAT         = 8'd4;
    localparam logic [7:0] TAG_LONG          = 8'd5;
    localparam logic [7:0] TAG_DOUBLE        = 8'd6;
    localparam logic [7:0] TAG_CLASS         = 8'd7;
    localparam logic [7:0] TAG_STRING        = 8'd8;
    localparam logic [7:0] TAG_FIELD_REF     = 8'd9;
    localparam logic [7:0] TAG_METHOD_REF    = 8'd10;
    localparam logic [7:0] TAG_IMETHOD_REF   = 8'd11;
    localparam logic [7:0] TAG_NAME_AND_TYPE = 8'd12;
    localparam logic [7:0] TAG_METHOD_HANDLE = 8'd15;
    localparam logic [7:0] TAG_METHOD_TYPE   = 8'd16;
    localparam logic [7:0] TAG_INVOKE_DYN    = 8'd18;
    localparam logic [7:0] TAG_END_OF_DATA   = 8'hFF;

    // Result kinds
    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_END_OF_DATA = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN_TAG = 2'd2;

    // Width of the field byte counter (longest entry has eight bytes)
    localparam int COUNT_W = 4;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  entry_tag;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [7:0]  text_byte;
        logic        last_text_byte;
        logic [1:0]  error_code;
    } result_t;

    // Field bytes that follow a tag; zero marks an unknown tag
    function automatic logic [COUNT_W-1:0] field_bytes(input logic [7:0] tag);
        logic [COUNT_W-1:0] n;
        unique case (tag)
            TAG_UTF8:          n = COUNT_W'(2);
            TAG_INTEGER,
            TAG_FLOAT:         n = COUNT_W'(4);
            TAG_LONG,
            TAG_DOUBLE:        n = COUNT_W'(8);
            TAG_CLASS,
            TAG_STRING,
            TAG_METHOD_TYPE:   n = COUNT_W'(2);
            TAG_FIELD_REF,
            TAG_METHOD_REF,
            TAG_IMETHOD_REF,
            TAG_NAME_AND_TYPE,
            TAG_INVOKE_DYN:    n = COUNT_W'(4);
            TAG_METHOD_HANDLE: n = COUNT_W'(3);
            default:           n = '0;
        endcase
        return n;
    endfunction

endpackage

@@ design/ccp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_in_if
// Byte stream channel into the parser: valid, ready and one data byte.
// ----------------------------------------------------------------------------
interface ccp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ design/ccp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_out_if
// Result channel out of the parser: valid, ready and the result fields.
// ----------------------------------------------------------------------------
interface ccp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  entry_tag;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [7:0]  text_byte;
    logic        last_text_byte;
    logic [1:0]  error_code;

    modport source (output valid, output result_kind, output entry_tag,
                    output first_value, output second_value, output text_byte,
                    output last_text_byte, output error_code, input ready);
    modport sink   (input valid, input result_kind, input entry_tag,
                    input first_value, input second_value, input text_byte,
                    input last_text_byte, input error_code, output ready);
endinterface

@@ design/class_constant_pool_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_constant_pool_parser
// Byte-stream parser for a class-file constant pool: one result per
// completed entry, per UTF8 text byte, or per bad tag.
// ----------------------------------------------------------------------------
// The parser takes one constant pool byte per clock cycle while input ready
// is high and produces at most one result per byte, registered in the output
// buffer. A two-entry output buffer lets the input keep running while one
// result waits; input ready drops only when both buffer slots are held.
// After an end-of-data or unknown-tag error, bytes are still accepted but
// are dropped without result until reset.
// ----------------------------------------------------------------------------
module class_constant_pool_parser
    import ccp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ccp_in_if.sink   in_ch,
    ccp_out_if.source out_ch
);

    logic    accept;
    logic    buf_full;
    logic    res_valid;
    result_t res;
    result_t out_data;

    // Take a byte whenever the result buffer has room
    assign in_ch.ready = !buf_full;
    assign accept      = in_ch.valid && !buf_full;

    ccp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (in_ch.data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    ccp_skid_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    // Drive the result fields
    assign out_ch.result_kind    = out_data.result_kind;
    assign out_ch.entry_tag      = out_data.entry_tag;
    assign out_ch.first_value    = out_data.first_value;
    assign out_ch.second_value   = out_data.second_value;
    assign out_ch.text_byte      = out_data.text_byte;
    assign out_ch.last_text_byte = out_data.last_text_byte;
    assign out_ch.error_code     = out_data.error_code;

endmodule

@@ design/ccp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_parser
// Parse state and per-byte decode: updates the entry state on each accepted
// byte and forms the result that the byte completes, if any.
// ----------------------------------------------------------------------------
module ccp_parser
    import ccp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_TAG,
        PH_FIELDS,
        PH_ULEN,
        PH_TEXT
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         tag_reg, tag_next;
    logic [COUNT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [63:0]        shift_reg, shift_next;
    logic [15:0]        text_left_reg, text_left_next;
    logic               halted_reg, halted_next;
    logic [COUNT_W-1:0] tag_bytes;

    assign tag_bytes = field_bytes(data_byte);

    // Decode one accepted byte
    always_comb
    begin
        phase_next      = phase_reg;
        tag_next        = tag_reg;
        bytes_left_next = bytes_left_reg;
        shift_next      = shift_reg;
        text_left_next  = text_left_reg;
        halted_next     = halted_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (accept && !halted_reg)
        begin
            unique case (phase_reg)
                PH_TAG:
                begin
                    tag_next   = data_byte;
                    shift_next = '0;
                    if (tag_bytes == '0)
                    begin
                        // Unknown or end tag: report and stop
                        halted_next     = 1'b1;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.entry_tag   = data_byte;
                        res.error_code  = (data_byte == TAG_END_OF_DATA) ?
                                          ERR_END_OF_DATA : ERR_UNKNOWN_TAG;
                    end
                    else
                    begin
                        bytes_left_next = tag_bytes;
                        phase_next = (data_byte == TAG_UTF8) ? PH_ULEN : PH_FIELDS;
                    end
                end
                PH_FIELDS:
                begin
                    shift_next      = {shift_reg[55:0], data_byte};
                    bytes_left_next = bytes_left_reg - COUNT_W'(1);
                    if (bytes_left_next == '0)
                    begin
                        phase_next      = PH_TAG;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ENTRY;
                        res.entry_tag   = tag_reg;
                        unique case (tag_reg)
                            TAG_LONG,
                            TAG_DOUBLE:
                            begin
                                res.first_value  = shift_next[63:32];
                                res.second_value = shift_next[31:0];
                            end
                            TAG_FIELD_REF,
                            TAG_METHOD_REF,
                            TAG_IMETHOD_REF,
                            TAG_NAME_AND_TYPE,
                            TAG_INVOKE_DYN:
                            begin
                                res.first_value  = {16'h0, shift_next[31:16]};
                                res.second_value = {16'h0, shift_next[15:0]};
                            end
                            TAG_METHOD_HANDLE:
                            begin
                                res.first_value  = {24'h0, shift_next[23:16]};
                                res.second_value = {16'h0, shift_next[15:0]};
                            end
                            TAG_CLASS,
                            TAG_STRING,
                            TAG_METHOD_TYPE:
                            begin
                                res.first_value = {16'h0, shift_next[15:0]};
                            end
                            default:
                            begin
                                // integer and float
                                res.first_value = shift_next[31:0];
                            end
                        endcase
                    end
                end
                PH_ULEN:
                begin
                    shift_next      = {48'h0, shift_reg[7:0], data_byte};
                    bytes_left_next = bytes_left_reg - COUNT_W'(1);
                    if (bytes_left_next == '0)
                    begin
                        text_left_next  = shift_next[15:0];
                        phase_next      = (shift_next[15:0] != 16'h0) ? PH_TEXT : PH_TAG;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ENTRY;
                        res.entry_tag   = tag_reg;
                        res.first_value = {16'h0, shift_next[15:0]};
                    end
                end
                PH_TEXT:
                begin
                    text_left_next = text_left_reg - 16'd1;
                    if (text_left_next == 16'h0)
                    begin
                        phase_next = PH_TAG;
                    end
                    res_valid          = 1'b1;
                    res.result_kind    = KIND_TEXT;
                    res.entry_tag      = tag_reg;
                    res.text_byte      = data_byte;
                    res.last_text_byte = (text_left_next == 16'h0);
                end
                default:
                begin
                    phase_next = PH_TAG;
                end
            endcase
        end
    end

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TAG;
            tag_reg        <= '0;
            bytes_left_reg <= '0;
            shift_reg      <= '0;
            text_left_reg  <= '0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tag_reg        <= tag_next;
            bytes_left_reg <= bytes_left_next;
            shift_reg      <= shift_next;
            text_left_reg  <= text_left_next;
            halted_reg     <= halted_next;
        end
    end

    // Once halted, no byte produces a result
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !res_valid)
        else $error("result produced while halted");

    // An error result always halts the parser
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.result_kind == KIND_ERROR) |=> halted_reg)
        else $error("error result did not halt the parser");

    // The last text byte returns the parser to the tag phase
    a_last_text_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.result_kind == KIND_TEXT && res.last_text_byte)
        |=> (phase_reg == PH_TAG))
        else $error("last text byte did not end the entry");

endmodule

@@ design/ccp_skid_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_skid_buf
// Two-entry result buffer: an output register backed by a skid register, so
// the input side never waits on the output ready combinationally.
// ----------------------------------------------------------------------------
module ccp_skid_buf
    import ccp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Advance the skid entry into the output slot when it frees
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Hold occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid entry is only used behind a waiting output request
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output slot");

    // A push into a full buffer would lose a request
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("push while buffer full");

    // The skid entry moves out as soon as the output request is taken
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry did not advance");

endmodule
